[hw/rtl/csm_pkg.sv]
// Shared constants, codes and control types for the contiguous sublist match unit.
package csm_pkg;

    localparam int TEXT_DEPTH    = 1024;
    localparam int PATTERN_DEPTH = 256;

    localparam int TEXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TEXT_CW = $clog2(TEXT_DEPTH + 1);
    localparam int PAT_AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PAT_CW  = $clog2(PATTERN_DEPTH + 1);
    localparam int SUM_W   = ((TEXT_CW > PAT_CW) ? TEXT_CW : PAT_CW) + 1;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEXT   = 2'd0,
        CMD_PAT    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } csm_cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } csm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_text;
        logic load_pat;
        logic start;
        logic step_k;
        logic step_s;
        logic finish;
        logic found;
    } csm_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic pat_empty;
        logic pat_longer;
        logic match;
        logic k_last;
        logic s_last;
        logic out_busy;
    } csm_stat_t;

endpackage

[hw/rtl/csm_if.sv]
// Request and result channel interfaces of the contiguous sublist match unit.
interface csm_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic signed [31:0]    value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface csm_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic overflow;

    modport source (output valid, output found, output overflow, input ready);
    modport sink   (input valid, input found, input overflow, output ready);
endinterface

[hw/rtl/csm_datapath.sv]
// Datapath: text and pattern stores, counts, search indexes, compare and result register.
module csm_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [csm_pkg::VALUE_W-1:0] value,
    input  csm_pkg::csm_ctl_t         ctl,
    input  logic                      rsp_ready,
    output csm_pkg::csm_stat_t        stat,
    output logic                      rsp_valid,
    output logic                      rsp_found,
    output logic                      rsp_overflow
);
    import csm_pkg::*;

    logic [VALUE_W-1:0] text_mem [TEXT_DEPTH];
    logic [VALUE_W-1:0] pat_mem  [PATTERN_DEPTH];

    logic [VALUE_W-1:0] text_rd_reg;
    logic [VALUE_W-1:0] pat_rd_reg;

    logic [TEXT_CW-1:0] text_count_reg, text_count_next;
    logic [PAT_CW-1:0]  pat_count_reg,  pat_count_next;
    logic               dropped_reg,    dropped_next;
    logic [TEXT_AW-1:0] s_reg,          s_next;
    logic [PAT_AW-1:0]  k_reg,          k_next;
    logic               rsp_valid_reg,  rsp_valid_next;
    logic               found_reg;
    logic               overflow_reg;

    logic               text_full;
    logic               pat_full;
    logic [SUM_W-1:0]   rd_sum;
    logic [TEXT_AW-1:0] text_rd_addr;

    assign text_full    = (text_count_reg == TEXT_CW'(TEXT_DEPTH));
    assign pat_full     = (pat_count_reg == PAT_CW'(PATTERN_DEPTH));
    assign rd_sum       = SUM_W'(s_reg) + SUM_W'(k_reg);
    assign text_rd_addr = rd_sum[TEXT_AW-1:0];

    // stores: write on load, registered read at the current search position
    always_ff @(posedge clk)
    begin
        if (ctl.load_text && !text_full)
        begin
            text_mem[text_count_reg[TEXT_AW-1:0]] <= value;
        end
        text_rd_reg <= text_mem[text_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_pat && !pat_full)
        begin
            pat_mem[pat_count_reg[PAT_AW-1:0]] <= value;
        end
        pat_rd_reg <= pat_mem[k_reg];
    end

    always_comb
    begin
        text_count_next = text_count_reg;
        pat_count_next  = pat_count_reg;
        dropped_next    = dropped_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        rsp_valid_next  = rsp_valid_reg;

        if (ctl.load_text)
        begin
            if (text_full)
                dropped_next = 1'b1;
            else
                text_count_next = text_count_reg + TEXT_CW'(1);
        end
        if (ctl.load_pat)
        begin
            if (pat_full)
                dropped_next = 1'b1;
            else
                pat_count_next = pat_count_reg + PAT_CW'(1);
        end
        if (ctl.start)
        begin
            s_next = '0;
            k_next = '0;
        end
        if (ctl.step_k)
        begin
            k_next = k_reg + PAT_AW'(1);
        end
        if (ctl.step_s)
        begin
            s_next = s_reg + TEXT_AW'(1);
            k_next = '0;
        end
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctl.finish)
        begin
            text_count_next = '0;
            pat_count_next  = '0;
            dropped_next    = 1'b0;
            rsp_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_count_reg <= '0;
            pat_count_reg  <= '0;
            dropped_reg    <= 1'b0;
            s_reg          <= '0;
            k_reg          <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            text_count_reg <= text_count_next;
            pat_count_reg  <= pat_count_next;
            dropped_reg    <= dropped_next;
            s_reg          <= s_next;
            k_reg          <= k_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            found_reg    <= ctl.found;
            overflow_reg <= dropped_reg;
        end
    end

    always_comb
    begin
        stat.pat_empty  = (pat_count_reg == '0);
        stat.pat_longer = (SUM_W'(pat_count_reg) > SUM_W'(text_count_reg));
        stat.match      = (text_rd_reg == pat_rd_reg);
        stat.k_last     = ((PAT_CW'(k_reg) + PAT_CW'(1)) == pat_count_reg);
        stat.s_last     = ((SUM_W'(s_reg) + SUM_W'(pat_count_reg)) == SUM_W'(text_count_reg));
        stat.out_busy   = rsp_valid_reg;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_found    = found_reg;
    assign rsp_overflow = overflow_reg;

endmodule

[hw/rtl/csm_ctrl.sv]
// Controller: request decode and the search state machine.
module csm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [csm_pkg::CMD_W-1:0]   req_cmd,
    input  csm_pkg::csm_stat_t          stat,
    output logic                        req_ready,
    output csm_pkg::csm_ctl_t           ctl
);
    import csm_pkg::*;

    csm_state_t state_reg, state_next;
    logic       accept;
    logic       is_search;

    assign is_search = (req_cmd == CMD_SEARCH);
    // a search waits until the previous result has left the output register
    assign req_ready = (state_reg == ST_IDLE) && !(is_search && stat.out_busy);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_search && !stat.pat_empty && !stat.pat_longer)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.match ? stat.k_last : stat.s_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_cmd)
                        CMD_TEXT:
                            ctl.load_text = 1'b1;
                        CMD_PAT:
                            ctl.load_pat = 1'b1;
                        CMD_SEARCH:
                        begin
                            if (stat.pat_empty)
                            begin
                                ctl.finish = 1'b1;
                                ctl.found  = 1'b1;
                            end
                            else if (stat.pat_longer)
                            begin
                                ctl.finish = 1'b1;
                            end
                            else
                            begin
                                ctl.start = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
            end
            ST_CMP:
            begin
                if (stat.match)
                begin
                    if (stat.k_last)
                    begin
                        ctl.finish = 1'b1;
                        ctl.found  = 1'b1;
                    end
                    else
                        ctl.step_k = 1'b1;
                end
                else if (stat.s_last)
                    ctl.finish = 1'b1;
                else
                    ctl.step_s = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/contiguous_sublist_match_unit.sv]
// Top level of the contiguous sublist match unit: controller plus datapath.
//
// Usage:
//   req channel: one request per element. cmd 0 appends value to the text
//   store (up to 1024 words), cmd 1 appends to the pattern store (up to 256
//   words), cmd 2 searches for the pattern as a contiguous run in the text,
//   cmd 3 is accepted and does nothing. A load that finds its store full is
//   dropped and sets the overflow flag.
//   rsp channel: one result per search: found, and overflow (an element was
//   dropped since the previous search). The search then empties both stores
//   and clears the flag.
// Timing:
//   Loads are accepted back to back while no search is walking, also while a
//   result waits in the output register.
//   A search holds the request side while it walks: each compare is one
//   registered read of both stores (READ) followed by the compare (CMP).
//   An empty pattern, or one longer than the text, answers without a walk.
//   The result is valid the cycle after the search ends.
// Reset and stall:
//   Reset empties both stores (counts to zero) and clears the flag and the
//   result valid. While the receiver stalls, the result holds, loads keep
//   flowing, and a new search is not accepted until the result is taken.
module contiguous_sublist_match_unit (
    input  logic          clk,
    input  logic          rst_n,
    csm_req_if.sink       req,
    csm_rsp_if.source     rsp
);
    import csm_pkg::*;

    csm_ctl_t  ctl;
    csm_stat_t stat;

    csm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .stat      (stat),
        .req_ready (req.ready),
        .ctl       (ctl)
    );

    csm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (req.value),
        .ctl          (ctl),
        .rsp_ready    (rsp.ready),
        .stat         (stat),
        .rsp_valid    (rsp.valid),
        .rsp_found    (rsp.found),
        .rsp_overflow (rsp.overflow)
    );

endmodule

[hw/rtl/csm_checker.sv]
// Port-level checker for the contiguous sublist match unit, with its bind.
module csm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_cmd,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_found,
    input logic       rsp_overflow
);
    import csm_pkg::*;

    logic search_acc;
    assign search_acc = req_valid && req_ready && (req_cmd == CMD_SEARCH);

    // a pending result holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_overflow))
        else $error("result dropped or changed while stalled");

    // a search is never accepted over a pending result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        search_acc |-> !rsp_valid)
        else $error("search accepted while result pending");

    // after a search, either the block is busy or the result is up
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        search_acc |=> !req_ready || rsp_valid)
        else $error("search accepted but neither busy nor answered");

    // a result only appears after a search or during a busy walk
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready || search_acc))
        else $error("result without a search");

endmodule

bind contiguous_sublist_match_unit csm_checker u_csm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_cmd      (req.cmd),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_overflow (rsp.overflow)
);

[tb/contiguous_sublist_match_unit_test.sv]
// Self-checking testbench for the contiguous sublist match unit.
`timescale 1ns / 100ps

module contiguous_sublist_match_unit_test;

    import csm_pkg::*;

    // Cycles with no handshake on either channel before the run is abandoned.
    // The slowest legal search here is the full-text one.
    localparam int WATCHDOG_LIMIT = 20000;
    // Length of the deliberate result-side hold-off.
    localparam int HOLD_CYCLES    = 400;
    // Load and search requests in the random part.
    localparam int RANDOM_ITEMS   = 1000;
    // Result shows up the cycle after the search ends; this is plenty.
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        csm_cmd_code_t   cmd;
        logic [31:0]     value;
    } request_t;

    typedef struct {
        logic found;
        logic overflow;
    } search_outcome_t;

    // Tracks both stores and the drop flag, and queues the outcome of each
    // accepted search for comparison against the result channel.
    class match_scoreboard;
        logic [31:0]       text_words[TEXT_DEPTH];
        logic [31:0]       pat_words[PATTERN_DEPTH];
        int unsigned       text_len;
        int unsigned       pat_len;
        bit                dropped;
        search_outcome_t   outcomes[$];
        int unsigned       searches;
        int unsigned       mismatches;

        function new();
            text_len   = 0;
            pat_len    = 0;
            dropped    = 0;
            searches   = 0;
            mismatches = 0;
        endfunction

        // Naive scan: every start position, first full match wins.
        function bit pattern_found();
            bit hit;
            if (pat_len == 0)
                return 1'b1;
            if (pat_len > text_len)
                return 1'b0;
            for (int unsigned s = 0; s + pat_len <= text_len; s++)
            begin
                hit = 1'b1;
                for (int unsigned k = 0; k < pat_len && hit; k++)
                    if (text_words[s + k] != pat_words[k])
                        hit = 1'b0;
                if (hit)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(csm_cmd_code_t cmd, logic [31:0] value);
            search_outcome_t o;
            case (cmd)
                CMD_TEXT:
                    if (text_len < TEXT_DEPTH)
                    begin
                        text_words[text_len] = value;
                        text_len++;
                    end
                    else
                        dropped = 1'b1;
                CMD_PAT:
                    if (pat_len < PATTERN_DEPTH)
                    begin
                        pat_words[pat_len] = value;
                        pat_len++;
                    end
                    else
                        dropped = 1'b1;
                CMD_SEARCH:
                begin
                    o.found    = pattern_found();
                    o.overflow = dropped;
                    outcomes.push_back(o);
                    text_len = 0;
                    pat_len  = 0;
                    dropped  = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic found, logic overflow);
            search_outcome_t want;
            searches++;
            if (outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d (found=%b overflow=%b) with no search pending",
                             $time, searches, found, overflow);
                return;
            end
            want = outcomes.pop_front();
            if (found !== want.found || overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d expected found=%b overflow=%b, got found=%b overflow=%b",
                             $time, searches, want.found, want.overflow, found, overflow);
            end
        endfunction

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    csm_req_if req_ch ();
    csm_rsp_if rsp_ch ();

    contiguous_sublist_match_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    match_scoreboard sb = new();

    request_t    batch[$];
    int unsigned loads_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic void enqueue_request(csm_cmd_code_t cmd, logic [31:0] value);
        request_t r;
        r.cmd   = cmd;
        r.value = value;
        batch.push_back(r);
    endfunction

    // Offer one request and return at the edge where it is taken. Valid stays
    // high on return so a back-to-back request needs no second assignment.
    // Each cycle before the offer is idle with the sender's idle percentage.
    task automatic send_request(csm_cmd_code_t cmd, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(cmd, value);
        if (cmd != CMD_NOP)
            loads_sent++;
    endtask

    task automatic send_batch();
        request_t r;
        while (batch.size() != 0)
        begin
            r = batch.pop_front();
            send_request(r.cmd, r.value);
        end
    endtask

    // Sender goes quiet until every search has been answered.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One random group. Mostly a well-formed text/pattern load with a search;
    // the rest is loose noise or a search after a short random mix of loads.
    task automatic queue_group();
        logic [31:0] pool[4];
        logic [31:0] text_seq[$];
        logic [31:0] pat_seq[$];
        int          pool_n;
        int          kind;
        int          variant;
        int          tl;
        int          pl;
        int          start;
        int          n;

        kind   = $urandom_range(99);
        pool_n = $urandom_range(2, 4);
        // Small alphabet per group so partial matches are common; the words
        // themselves span the whole 32-bit range.
        for (int i = 0; i < 4; i++)
            case ($urandom_range(3))
                0:       pool[i] = $urandom;
                1:       pool[i] = 32'hFFFF_FFFF;
                2:       pool[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: pool[i] = $urandom_range(3);
            endcase

        if (kind < 80)
        begin
            tl = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 20);
            for (int i = 0; i < tl; i++)
                text_seq.push_back(pool[$urandom_range(pool_n - 1)]);
            variant = $urandom_range(3);
            if (variant < 3)
            begin
                // slice of the text; the third flavor spoils its last word
                if (tl != 0)
                begin
                    pl    = $urandom_range(1, (tl < 6) ? tl : 6);
                    start = $urandom_range(0, tl - pl);
                    for (int i = 0; i < pl; i++)
                        pat_seq.push_back(text_seq[start + i]);
                    if (variant == 2)
                        pat_seq[pl - 1] = pool[$urandom_range(pool_n - 1)];
                end
            end
            else
            begin
                pl = $urandom_range(0, 6);
                for (int i = 0; i < pl; i++)
                    pat_seq.push_back(pool[$urandom_range(pool_n - 1)]);
            end
            // text and pattern loads interleave freely, with stray no-ops
            while (text_seq.size() != 0 || pat_seq.size() != 0)
            begin
                if ($urandom_range(14) == 0)
                    enqueue_request(CMD_NOP, $urandom);
                else if (pat_seq.size() == 0 || (text_seq.size() != 0 && $urandom_range(1)))
                    enqueue_request(CMD_TEXT, text_seq.pop_front());
                else
                    enqueue_request(CMD_PAT, pat_seq.pop_front());
            end
            enqueue_request(CMD_SEARCH, $urandom);
        end
        else if (kind < 92)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                enqueue_request(csm_cmd_code_t'($urandom_range(3)), $urandom);
        end
        else
        begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                enqueue_request($urandom_range(1) ? CMD_TEXT : CMD_PAT,
                                pool[$urandom_range(pool_n - 1)]);
            enqueue_request(CMD_SEARCH, $urandom);
        end
    endtask

    // Fill each store past its depth, and fill the pattern store exactly.
    task automatic overrun_stores();
        logic [31:0] kept[$];
        logic [31:0] w;

        // Full text plus two dropped words; pattern is the last four stored
        // words, so the match sits at the very end of the text.
        for (int i = 0; i < TEXT_DEPTH + 2; i++)
        begin
            w = $urandom;
            kept.push_back(w);
            enqueue_request(CMD_TEXT, w);
        end
        for (int i = 0; i < 4; i++)
            enqueue_request(CMD_PAT, kept[TEXT_DEPTH - 4 + i]);
        enqueue_request(CMD_SEARCH, 32'h0);
        send_batch();

        // Pattern store filled to the brim, no drop: found, no overflow.
        kept.delete();
        for (int i = 0; i < PATTERN_DEPTH + 44; i++)
        begin
            w = $urandom;
            kept.push_back(w);
            enqueue_request(CMD_TEXT, w);
        end
        for (int i = 0; i < PATTERN_DEPTH; i++)
            enqueue_request(CMD_PAT, kept[40 + i]);
        enqueue_request(CMD_SEARCH, 32'h0);

        // Pattern store overrun against a short text.
        for (int i = 0; i < PATTERN_DEPTH + 2; i++)
            enqueue_request(CMD_PAT, $urandom);
        enqueue_request(CMD_TEXT, $urandom);
        enqueue_request(CMD_TEXT, $urandom);
        enqueue_request(CMD_SEARCH, 32'h0);
        // flag must be gone on the next search
        enqueue_request(CMD_SEARCH, 32'h0);
        send_batch();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned target;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= CMD_NOP;
        req_ch.value   <= 32'h0;
        loads_sent     = 0;
        hold_request   = 1'b0;
        send_idle_pct  = 14;
        recv_stall_pct = 55;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stores, range extremes, no-op, pattern longer than
        // text, match after a false start, equal-length miss.
        enqueue_request(CMD_SEARCH, 32'hFFFF_FFFF);
        enqueue_request(CMD_TEXT, 32'h8000_0000);
        enqueue_request(CMD_TEXT, 32'h7FFF_FFFF);
        enqueue_request(CMD_TEXT, 32'hFFFF_FFFF);
        enqueue_request(CMD_PAT, 32'h7FFF_FFFF);
        enqueue_request(CMD_NOP, 32'h1234_5678);
        enqueue_request(CMD_PAT, 32'hFFFF_FFFF);
        enqueue_request(CMD_SEARCH, 32'h0);
        enqueue_request(CMD_TEXT, 32'h8000_0000);
        enqueue_request(CMD_SEARCH, 32'h0);
        enqueue_request(CMD_PAT, 32'h0);
        enqueue_request(CMD_PAT, 32'h0);
        enqueue_request(CMD_TEXT, 32'h0);
        enqueue_request(CMD_SEARCH, 32'h0);
        enqueue_request(CMD_TEXT, 32'h1);
        enqueue_request(CMD_TEXT, 32'h1);
        enqueue_request(CMD_TEXT, 32'h2);
        enqueue_request(CMD_PAT, 32'h1);
        enqueue_request(CMD_PAT, 32'h2);
        enqueue_request(CMD_SEARCH, 32'h0);
        enqueue_request(CMD_TEXT, 32'h5);
        enqueue_request(CMD_PAT, 32'h6);
        enqueue_request(CMD_SEARCH, 32'h0);
        send_batch();
        drain_results();

        overrun_stores();
        drain_results();

        // Random part in three idle profiles; the sender pauses for all
        // answers between them.
        target = loads_sent + RANDOM_ITEMS;
        while (loads_sent < target - 2 * RANDOM_ITEMS / 3)
        begin
            queue_group();
            send_batch();
        end
        drain_results();

        send_idle_pct  = 55;
        recv_stall_pct = 14;
        // Result side goes dark while loads and searches keep coming; the
        // second search in flight has to stall the request side.
        hold_request   = 1'b1;
        while (loads_sent < target - RANDOM_ITEMS / 3)
        begin
            queue_group();
            send_batch();
        end
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (loads_sent < target)
        begin
            queue_group();
            send_batch();
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check each taken result, then pick next ready.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.found, rsp_ch.overflow);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/csm_pkg.sv
hw/rtl/csm_if.sv
hw/rtl/csm_datapath.sv
hw/rtl/csm_ctrl.sv
hw/rtl/contiguous_sublist_match_unit.sv
hw/rtl/csm_checker.sv
tb/contiguous_sublist_match_unit_test.sv
